// ===== rtl/xed_pkg.sv =====
package xed_pkg;

	localparam int MAX_REF_LEN = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int NAME_CNT    = 5;
	localparam int CODE_W      = 21;
	localparam int UTF_MAX     = 4;
	localparam int TCNT_W      = 3;

	localparam logic [CODE_W-1:0] CODE_MAX = 21'h1FFFFF;
	localparam logic [CODE_W-1:0] LIM_1    = 21'h00007F;
	localparam logic [CODE_W-1:0] LIM_2    = 21'h0007FF;
	localparam logic [CODE_W-1:0] LIM_3    = 21'h00FFFF;

	localparam logic [7:0] LEAD_2 = 8'hC0;
	localparam logic [7:0] LEAD_3 = 8'hE0;
	localparam logic [7:0] LEAD_4 = 8'hF0;
	localparam logic [7:0] CONT   = 8'h80;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_X_LO = 8'h78;
	localparam logic [7:0] CH_X_UP = 8'h58;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_A_LO = 8'h61;
	localparam logic [7:0] CH_F_LO = 8'h66;
	localparam logic [7:0] CH_A_UP = 8'h41;
	localparam logic [7:0] CH_F_UP = 8'h46;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_AMP,
		MODE_NAME,
		MODE_HASH,
		MODE_DIGIT
	} mode_t;

	typedef enum logic [2:0] {
		NAME_LT,
		NAME_AMP,
		NAME_GT,
		NAME_QUOT,
		NAME_APOS
	} name_t;

	typedef struct packed {
		logic [UTF_MAX-1:0][7:0] bytes;
		logic [TCNT_W-1:0]       cnt;
	} tail_t;

	function automatic logic [2:0] name_len(input logic [2:0] k);
		logic [2:0] r;
		case (k)
			NAME_LT:   r = 3'd3;
			NAME_AMP:  r = 3'd4;
			NAME_GT:   r = 3'd3;
			NAME_QUOT: r = 3'd5;
			NAME_APOS: r = 3'd5;
			default:   r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] name_out(input logic [2:0] k);
		logic [7:0] r;
		case (k)
			NAME_LT:   r = 8'h3C;
			NAME_AMP:  r = 8'h26;
			NAME_GT:   r = 8'h3E;
			NAME_QUOT: r = 8'h22;
			NAME_APOS: r = 8'h27;
			default:   r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] name_char(input logic [2:0] k, input logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		case (k)
			NAME_LT: begin
				case (i)
					3'd0:    r = 8'h6C;
					3'd1:    r = 8'h74;
					3'd2:    r = CH_SEMI;
					default: r = 8'h00;
				endcase
			end
			NAME_AMP: begin
				case (i)
					3'd0:    r = 8'h61;
					3'd1:    r = 8'h6D;
					3'd2:    r = 8'h70;
					3'd3:    r = CH_SEMI;
					default: r = 8'h00;
				endcase
			end
			NAME_GT: begin
				case (i)
					3'd0:    r = 8'h67;
					3'd1:    r = 8'h74;
					3'd2:    r = CH_SEMI;
					default: r = 8'h00;
				endcase
			end
			NAME_QUOT: begin
				case (i)
					3'd0:    r = 8'h71;
					3'd1:    r = 8'h75;
					3'd2:    r = 8'h6F;
					3'd3:    r = 8'h74;
					3'd4:    r = CH_SEMI;
					default: r = 8'h00;
				endcase
			end
			NAME_APOS: begin
				case (i)
					3'd0:    r = 8'h61;
					3'd1:    r = 8'h70;
					3'd2:    r = 8'h6F;
					3'd3:    r = 8'h73;
					3'd4:    r = CH_SEMI;
					default: r = 8'h00;
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/xed_front.sv =====
module xed_front #(
	parameter int MAX_REF_LEN = xed_pkg::MAX_REF_LEN,
	localparam int HC_W = $clog2(MAX_REF_LEN)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [7:0]                    in_byte,
	input  logic                          end_of_text,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          q_full,
	output logic                          cmd_push,
	output logic [MAX_REF_LEN-1:0][7:0]   cmd_held,
	output logic [HC_W-1:0]               cmd_hcnt,
	output xed_pkg::tail_t                cmd_tail
);

	localparam int VAL_W = xed_pkg::CODE_W + 4;

	xed_pkg::mode_t mode_q, mode_d;
	logic [MAX_REF_LEN-1:0][7:0]    hb_q;
	logic [HC_W-1:0]                hc_q, hc_d;
	logic [xed_pkg::CODE_W-1:0]     code_q, code_d;
	logic                           hex_q, hex_d;
	logic                           ovf_q, ovf_d;
	logic [xed_pkg::NAME_CNT-1:0]   cand_q, cand_d;

	logic                           accept;
	logic                           is_amp, is_hash, is_semi, is_x;
	logic                           dig_ok;
	logic [3:0]                     dig_val;
	logic                           can_hold;
	logic [xed_pkg::NAME_CNT-1:0]   cand, hit, done;
	logic [2:0]                     npos;
	logic [7:0]                     name_sel;
	logic [VAL_W-1:0]               prod, nv;
	logic                           act_hold, act_name, act_enc, rescan;
	logic                           set_hex, dig_upd;
	xed_pkg::mode_t                 hold_mode;
	logic                           keep, start_ref;
	xed_pkg::tail_t                 enc;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;

	assign is_amp  = in_byte == xed_pkg::CH_AMP;
	assign is_hash = in_byte == xed_pkg::CH_HASH;
	assign is_semi = in_byte == xed_pkg::CH_SEMI;
	assign is_x    = in_byte == xed_pkg::CH_X_LO || in_byte == xed_pkg::CH_X_UP;

	assign can_hold = ((HC_W+1)'(hc_q) + (HC_W+1)'(1)) < (HC_W+1)'(MAX_REF_LEN);

	always_comb begin
		dig_ok  = 1'b0;
		dig_val = 4'd0;
		if (in_byte >= xed_pkg::CH_0 && in_byte <= xed_pkg::CH_9) begin
			dig_ok  = 1'b1;
			dig_val = 4'(in_byte - xed_pkg::CH_0);
		end else if (hex_q && in_byte >= xed_pkg::CH_A_LO && in_byte <= xed_pkg::CH_F_LO) begin
			dig_ok  = 1'b1;
			dig_val = 4'(in_byte - xed_pkg::CH_A_LO + 8'd10);
		end else if (hex_q && in_byte >= xed_pkg::CH_A_UP && in_byte <= xed_pkg::CH_F_UP) begin
			dig_ok  = 1'b1;
			dig_val = 4'(in_byte - xed_pkg::CH_A_UP + 8'd10);
		end
	end

	assign prod = hex_q ? {code_q, 4'b0000}
	                    : ({1'b0, code_q, 3'b000} + {3'b000, code_q, 1'b0});
	assign nv   = prod + VAL_W'(dig_val);

	assign cand = (mode_q == xed_pkg::MODE_AMP) ? '1 : cand_q;
	assign npos = 3'(hc_q - HC_W'(1));

	always_comb begin
		name_sel = 8'h00;
		for (int k = 0; k < xed_pkg::NAME_CNT; k++) begin
			hit[k]  = cand[k] && (hc_q <= HC_W'(xed_pkg::name_len(3'(k))))
			          && (xed_pkg::name_char(3'(k), npos) == in_byte);
			done[k] = hit[k] && (hc_q == HC_W'(xed_pkg::name_len(3'(k))));
			if (done[k])
				name_sel = xed_pkg::name_out(3'(k));
		end
	end

	always_comb begin
		act_hold  = 1'b0;
		act_name  = 1'b0;
		act_enc   = 1'b0;
		rescan    = 1'b0;
		set_hex   = 1'b0;
		dig_upd   = 1'b0;
		hold_mode = xed_pkg::MODE_IDLE;
		case (mode_q)
			xed_pkg::MODE_AMP, xed_pkg::MODE_NAME: begin
				if (mode_q == xed_pkg::MODE_AMP && is_hash) begin
					act_hold  = 1'b1;
					hold_mode = xed_pkg::MODE_HASH;
				end else if (|done) begin
					act_name = 1'b1;
				end else if (|hit && can_hold) begin
					act_hold  = 1'b1;
					hold_mode = xed_pkg::MODE_NAME;
				end else begin
					rescan = 1'b1;
				end
			end
			xed_pkg::MODE_HASH, xed_pkg::MODE_DIGIT: begin
				if (mode_q == xed_pkg::MODE_HASH && is_x) begin
					if (can_hold) begin
						act_hold  = 1'b1;
						set_hex   = 1'b1;
						hold_mode = xed_pkg::MODE_DIGIT;
					end else begin
						rescan = 1'b1;
					end
				end else if (is_semi) begin
					if (ovf_q)
						rescan = 1'b1;
					else
						act_enc = 1'b1;
				end else if (dig_ok && can_hold) begin
					act_hold  = 1'b1;
					dig_upd   = 1'b1;
					hold_mode = xed_pkg::MODE_DIGIT;
				end else begin
					rescan = 1'b1;
				end
			end
			default: begin
				rescan = 1'b1;
			end
		endcase
	end

	assign keep      = act_hold && !end_of_text;
	assign start_ref = rescan && is_amp && !end_of_text;

	always_comb begin
		mode_d = xed_pkg::MODE_IDLE;
		hc_d   = '0;
		code_d = '0;
		hex_d  = 1'b0;
		ovf_d  = 1'b0;
		cand_d = cand_q;
		if (keep) begin
			mode_d = hold_mode;
			hc_d   = hc_q + HC_W'(1);
			code_d = code_q;
			hex_d  = hex_q || set_hex;
			ovf_d  = ovf_q;
			cand_d = hit;
			if (dig_upd && !ovf_q) begin
				if (nv > VAL_W'(xed_pkg::CODE_MAX))
					ovf_d = 1'b1;
				else
					code_d = nv[xed_pkg::CODE_W-1:0];
			end
		end else if (start_ref) begin
			mode_d = xed_pkg::MODE_AMP;
			hc_d   = HC_W'(1);
		end
	end

	always_comb begin
		enc = '0;
		if (code_q <= xed_pkg::LIM_1) begin
			enc.bytes[0] = code_q[7:0];
			enc.cnt      = 3'd1;
		end else if (code_q <= xed_pkg::LIM_2) begin
			enc.bytes[0] = xed_pkg::LEAD_2 | {3'b000, code_q[10:6]};
			enc.bytes[1] = xed_pkg::CONT | {2'b00, code_q[5:0]};
			enc.cnt      = 3'd2;
		end else if (code_q <= xed_pkg::LIM_3) begin
			enc.bytes[0] = xed_pkg::LEAD_3 | {4'b0000, code_q[15:12]};
			enc.bytes[1] = xed_pkg::CONT | {2'b00, code_q[11:6]};
			enc.bytes[2] = xed_pkg::CONT | {2'b00, code_q[5:0]};
			enc.cnt      = 3'd3;
		end else begin
			enc.bytes[0] = xed_pkg::LEAD_4 | {5'b00000, code_q[20:18]};
			enc.bytes[1] = xed_pkg::CONT | {2'b00, code_q[17:12]};
			enc.bytes[2] = xed_pkg::CONT | {2'b00, code_q[11:6]};
			enc.bytes[3] = xed_pkg::CONT | {2'b00, code_q[5:0]};
			enc.cnt      = 3'd4;
		end
	end

	always_comb begin
		cmd_held = hb_q;
		cmd_hcnt = (rescan || (act_hold && end_of_text)) ? hc_q : '0;
		cmd_tail = '0;
		if (act_name) begin
			cmd_tail.bytes[0] = name_sel;
			cmd_tail.cnt      = 3'd1;
		end else if (act_enc) begin
			cmd_tail = enc;
		end else if ((rescan && (!is_amp || end_of_text)) || (act_hold && end_of_text)) begin
			cmd_tail.bytes[0] = in_byte;
			cmd_tail.cnt      = 3'd1;
		end
		cmd_push = accept && (cmd_hcnt != '0 || cmd_tail.cnt != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= xed_pkg::MODE_IDLE;
			hc_q   <= '0;
			code_q <= '0;
			hex_q  <= 1'b0;
			ovf_q  <= 1'b0;
			cand_q <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			hc_q   <= hc_d;
			code_q <= code_d;
			hex_q  <= hex_d;
			ovf_q  <= ovf_d;
			cand_q <= cand_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && keep)
			hb_q[hc_q] <= in_byte;
		else if (accept && start_ref)
			hb_q[0] <= xed_pkg::CH_AMP;
	end

endmodule

// ===== rtl/xed_fifo.sv =====
module xed_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = xed_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign full  = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

endmodule

// ===== rtl/xed_back.sv =====
module xed_back #(
	parameter int MAX_REF_LEN = xed_pkg::MAX_REF_LEN,
	localparam int HC_W = $clog2(MAX_REF_LEN)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  logic [MAX_REF_LEN-1:0][7:0] q_held,
	input  logic [HC_W-1:0]             q_hcnt,
	input  xed_pkg::tail_t              q_tail,
	output logic                        q_pop,
	output logic [7:0]                  out_byte,
	output logic                        last_of_run,
	output logic                        out_valid,
	input  logic                        out_ready
);

	logic                            cur_valid_q;
	logic [MAX_REF_LEN-1:0][7:0]     ch_q;
	logic [HC_W-1:0]                 chc_q;
	logic [xed_pkg::UTF_MAX-1:0][7:0] ct_q;
	logic [xed_pkg::TCNT_W-1:0]      ctc_q;
	logic                            ovalid_q;
	logic [7:0]                      obyte_q;
	logic                            olast_q;

	logic adv, emit, one_left, from_held;

	assign adv       = !ovalid_q || out_ready;
	assign emit      = cur_valid_q && adv;
	assign from_held = chc_q != '0;
	assign one_left  = (chc_q == HC_W'(1) && ctc_q == '0)
	                || (chc_q == '0 && ctc_q == xed_pkg::TCNT_W'(1));
	assign q_pop     = !q_empty && (!cur_valid_q || (emit && one_left));

	assign out_valid   = ovalid_q;
	assign out_byte    = obyte_q;
	assign last_of_run = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			chc_q       <= '0;
			ctc_q       <= '0;
			ovalid_q    <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				chc_q       <= q_hcnt;
				ctc_q       <= q_tail.cnt;
			end else if (emit && one_left) begin
				cur_valid_q <= 1'b0;
				chc_q       <= '0;
				ctc_q       <= '0;
			end else if (emit) begin
				if (from_held)
					chc_q <= chc_q - HC_W'(1);
				else
					ctc_q <= ctc_q - xed_pkg::TCNT_W'(1);
			end
			if (emit)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ch_q <= q_held;
			ct_q <= q_tail.bytes;
		end else if (emit) begin
			if (from_held)
				ch_q <= ch_q >> 8;
			else
				ct_q <= ct_q >> 8;
		end
		if (emit) begin
			obyte_q <= from_held ? ch_q[0] : ct_q[0];
			olast_q <= one_left;
		end
	end

endmodule

// ===== rtl/xml_entity_decoder.sv =====
// Streaming decoder for XML character references, one text byte per transfer.
// Input channel: in_byte with end_of_text, on in_valid / in_ready. Plain bytes
// pass through; &lt; &amp; &gt; &quot; &apos; and &#ddd; / &#xhh; references
// become their character (numeric ones as 1 to 4 bytes of UTF-8). Bytes of an
// open reference are held back; a failing reference releases them literally.
// Output channel: out_byte with last_of_run, on out_valid / out_ready;
// last_of_run marks the final result byte caused by one input byte. An input
// byte that only extends a reference gives no output.
// Throughput, unless stalled: one input byte and one output byte per cycle. An
// input whose work yields k result bytes keeps the output busy until all k are
// sent; the command queue between the scanner and the emitter absorbs such
// runs, and the input stalls only when that queue (QUEUE_DEPTH entries) is
// full. The first result byte passes the queue and the emitter's registers.
// Reset clears the scanner state (no open reference), the queue and the output
// register; no clearing pass is needed. When the receiver holds out_ready low,
// the output byte holds, the emitter and queue fill, and in_ready then drops.
module xml_entity_decoder #(
	parameter int MAX_REF_LEN = xed_pkg::MAX_REF_LEN,
	parameter int QUEUE_DEPTH = xed_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	input  logic       in_valid,
	output logic       in_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       out_valid,
	input  logic       out_ready
);

	localparam int HC_W  = $clog2(MAX_REF_LEN);
	localparam int CMD_W = MAX_REF_LEN * 8 + HC_W + $bits(xed_pkg::tail_t);

	logic                        cmd_push, q_full, q_empty, q_pop;
	logic [MAX_REF_LEN-1:0][7:0] cmd_held, q_held;
	logic [HC_W-1:0]             cmd_hcnt, q_hcnt;
	xed_pkg::tail_t              cmd_tail, q_tail;
	logic [CMD_W-1:0]            q_wdata, q_rdata;

	xed_front #(
		.MAX_REF_LEN(MAX_REF_LEN)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.q_full     (q_full),
		.cmd_push   (cmd_push),
		.cmd_held   (cmd_held),
		.cmd_hcnt   (cmd_hcnt),
		.cmd_tail   (cmd_tail)
	);

	assign q_wdata = {cmd_held, cmd_hcnt, cmd_tail};
	assign {q_held, q_hcnt, q_tail} = q_rdata;

	xed_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	xed_back #(
		.MAX_REF_LEN(MAX_REF_LEN)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_held     (q_held),
		.q_hcnt     (q_hcnt),
		.q_tail     (q_tail),
		.q_pop      (q_pop),
		.out_byte   (out_byte),
		.last_of_run(last_of_run),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

endmodule
